@@ hdl/smdw_pkg.sv @@
// Package with opcode, state and field types for the sign-magnitude ALU.
package smdw_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_MOD = 4'd4,
    OP_SHL = 4'd5, OP_SHR = 4'd6, OP_AND = 4'd7, OP_OR = 4'd8, OP_XOR = 4'd9,
    OP_NOT = 4'd10, OP_NEG = 4'd11, OP_INC = 4'd12, OP_DEC = 4'd13,
    OP_CMP = 4'd14, OP_NONE = 4'd15
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ITER = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam int MAG_W = 64;
  localparam int IN_W  = 144;
  localparam int OUT_W = 72;

endpackage

@@ hdl/sign_magnitude_double_word_alu.sv @@
// Top level of the sign-magnitude double-word ALU with a shared shift-add unit.
//
// Channel  Dir  Payload
// s_axis   in   op, a_neg, a_mag, b_neg, b_mag, shift_amount
// m_axis   out  r_neg, r_mag, order, div_zero
//
// Multiply, divide and modulo take 2*WORD_BITS adder steps in ST_ITER, then ST_FIN
// writes the result into the output register; other operations go straight to ST_FIN.
// The next transaction is accepted only once the result has been taken and the
// sequencer is back in idle; s_axis_tready is low meanwhile.
// A stalled result holds in the output register until m_axis_tready.
// Reset returns the sequencer to idle and empties the output register.
module sign_magnitude_double_word_alu #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // op[3:0], a_neg[4], a_mag[68:5], b_neg[69], b_mag[133:70], shift_amount[140:134]
  input  logic [smdw_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // r_neg[0], r_mag[64:1], order[66:65], div_zero[67]
  output logic [smdw_pkg::OUT_W-1:0]  m_axis_tdata
);
  import smdw_pkg::*;

  localparam int DW  = 2 * WORD_BITS;
  localparam int CW  = $clog2(DW + 1);

  state_t          state;
  op_t             op;
  logic            an, bn;
  logic [DW-1:0]   am, bm;
  logic [6:0]      sh;
  logic [DW-1:0]   acc, q;
  logic [CW-1:0]   cnt;
  logic            rn;
  logic [DW-1:0]   rm;
  logic [1:0]      ord;
  logic            dz;

  logic [DW-1:0]   in_am, in_bm;
  logic [DW:0]     sum, rem_sh, rem_sub;
  logic            in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_am = s_axis_tdata[5 +: DW];
  assign in_bm = s_axis_tdata[70 +: DW];

  assign rem_sh  = {acc, q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, bm};
  assign sum     = {1'b0, acc} + (q[0] ? {1'b0, am} : '0);

  always_comb begin
    logic          gt, lt;
    logic [DW:0]   d;
    logic          srn;
    srn = 1'b0;
    d   = '0;
    gt  = am > bm;
    lt  = am < bm;
    if (an != bn) ord = an ? 2'b11 : 2'b01;
    else if (gt) ord = an ? 2'b11 : 2'b01;
    else if (lt) ord = an ? 2'b01 : 2'b11;
    else ord = 2'b00;
    rn = 1'b0;
    rm = '0;
    dz = 1'b0;
    unique case (op) inside
      OP_ADD, OP_SUB: begin
        srn = (op == OP_SUB) ? (~bn && bm != '0) : bn;
        if (an == srn) begin
          d = {1'b0, am} + {1'b0, bm};
          rn = an;
        end else if (!lt) begin
          d = {1'b0, am} - {1'b0, bm};
          rn = an;
        end else begin
          d = {1'b0, bm} - {1'b0, am};
          rn = ~an;
        end
        rm = d[DW-1:0];
      end
      OP_MUL: begin rn = an ^ bn; rm = q; end
      OP_DIV: begin
        if (bm == '0) dz = 1'b1;
        else begin rn = an ^ bn; rm = q; end
      end
      OP_MOD: begin
        rn = an;
        if (bm == '0) begin dz = 1'b1; rm = am; end
        else rm = acc;
      end
      OP_SHL: begin rn = an; rm = (sh >= 7'(DW)) ? '0 : am << sh; end
      OP_SHR: begin rn = an; rm = (sh >= 7'(DW)) ? '0 : am >> sh; end
      OP_AND: begin rn = an; rm = am & bm; end
      OP_OR:  begin rn = an; rm = am | bm; end
      OP_XOR: begin rn = an; rm = am ^ bm; end
      OP_NOT: begin rn = an; rm = ~am; end
      OP_NEG: begin rn = ~an; rm = am; end
      OP_INC: begin rn = an; rm = an ? am - 1'b1 : am + 1'b1; end
      OP_DEC: begin
        if (an) begin rn = 1'b1; rm = am + 1'b1; end
        else if (am == '0) begin rn = 1'b1; rm = DW'(1); end
        else begin rn = 1'b0; rm = am - 1'b1; end
      end
      default: begin rn = 1'b0; rm = '0; end
    endcase
    if (rm == '0) rn = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            op  <= op_t'(s_axis_tdata[3:0]);
            am  <= in_am;
            bm  <= in_bm;
            an  <= s_axis_tdata[4] && in_am != '0;
            bn  <= s_axis_tdata[69] && in_bm != '0;
            sh  <= s_axis_tdata[140:134];
            cnt <= CW'(DW);
            acc <= '0;
            q   <= (op_t'(s_axis_tdata[3:0]) == OP_MUL) ? in_bm : in_am;
            state <= (op_t'(s_axis_tdata[3:0]) == OP_MUL ||
                      op_t'(s_axis_tdata[3:0]) == OP_DIV ||
                      op_t'(s_axis_tdata[3:0]) == OP_MOD) ? ST_ITER : ST_FIN;
          end
        end
        ST_ITER: begin
          if (op == OP_MUL) begin
            acc <= sum[DW:1];
            q   <= {sum[0], q[DW-1:1]};
          end else if (!rem_sub[DW]) begin
            acc <= rem_sub[DW-1:0];
            q   <= {q[DW-2:0], 1'b1};
          end else begin
            acc <= rem_sh[DW-1:0];
            q   <= {q[DW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) state <= ST_FIN;
        end
        ST_FIN: begin
          m_axis_tdata  <= {4'(0), dz, ord, MAG_W'(rm), rn};
          m_axis_tvalid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result held");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result lost");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[64:1] != '0)
    else $error("negative zero");
  a_iter: assert property (@(posedge clk) disable iff (rst)
    state == ST_ITER |-> cnt != '0) else $error("count underflow");
endmodule
